/* hdl/uer_pkg.sv */
// ---------------------------------------------------------------------------
// uer_pkg - shared types and constants for the echo ranger core
// Word formats, event and phase codes, divider reciprocal and bounds.
// ---------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

   localparam int TIME_WIDTH_DEF = 32;

   localparam int MIN_CFG_W = 9;
   localparam int TMO_CFG_W = 10;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_IDX_W = 1;
   localparam int ELAPSED_W = 11;
   localparam int CNT_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISTANCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 1'd1;

   localparam logic [MIN_CFG_W-1:0] MIN_DISTANCE_RST = 9'd2;
   localparam logic [TMO_CFG_W-1:0] TIMEOUT_RST = 10'd35;

   localparam logic [1:0] FN_START = 2'd0;
   localparam logic [1:0] FN_EDGE = 2'd1;
   localparam logic [1:0] FN_TICK = 2'd2;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 11'd2047;

   // bounds: min * 58 fits 15 bits, timeout * 1000 fits 20 bits
   localparam int MIN_BND_W = 15;
   localparam int MAX_BND_W = 20;
   localparam logic [MIN_BND_W-1:0] US_PER_CM = 15'd58;
   localparam logic [MAX_BND_W-1:0] US_PER_MS = 20'd1000;

   // a valid echo is below 2^20, so x/58 = (x * ceil(2^32/58)) >> 32 exactly
   localparam int DIV_IN_W = 20;
   localparam int RECIP_W = 27;
   localparam int PROD_W = DIV_IN_W + RECIP_W;
   localparam int RECIP_SHIFT = 32;
   localparam logic [RECIP_W-1:0] RECIP_58 = 27'd74051161;
   localparam int DIST_W = 16;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_WAIT_RISE = 3'd1,
      PH_WAIT_FALL = 3'd2,
      PH_DONE = 3'd3,
      PH_TIMEOUT = 3'd4
   } phase_type;

   typedef struct packed {
      logic [1:0] func;
      logic [31:0] capture_time;
   } req_word_type;

   typedef struct packed {
      logic [2:0] phase;
      logic [31:0] echo_width_us;
      logic [15:0] range_cm;
      logic distance_valid;
      logic trigger_fire;
      logic [31:0] starts_seen;
      logic [31:0] rises_seen;
      logic [31:0] falls_seen;
      logic [31:0] timeouts_seen;
   } rsp_word_type;

endpackage

`default_nettype wire

/* hdl/ultrasonic_echo_ranger_core.sv */
// ---------------------------------------------------------------------------
// ultrasonic_echo_ranger_core - echo pulse distance measurement
// Start/edge/tick event sequencer with echo width, distance and counters.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one event word (start, echo edge with timestamp, or 1 ms
//   tick); rsp_* returns one status word per event, in order. Both use
//   valid/ready. csr_* writes the minimum distance (index 0) and the
//   timeout (index 1); write only while no event is in flight.
// Path: the state update is done at accept and held with the event in
//   the middle stage; from there the distance bounds are checked and the
//   echo width is divided by 58 with a reciprocal multiply into the
//   output register, which drives rsp_valid.
// Throughput: one event per cycle while the output is not stalled.
// Stall: while rsp_ready is low the output word holds, the middle stage
//   fills, and req_ready drops once both are occupied.
// Reset: clears state, counters, config to defaults and both stages.
// ---------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger_core #(
   parameter int TIME_WIDTH = uer_pkg::TIME_WIDTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire uer_pkg::req_word_type req_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output uer_pkg::rsp_word_type rsp_data,
   input wire logic csr_we,
   input wire logic [uer_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [uer_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // config
   logic [uer_pkg::MIN_CFG_W-1:0] min_dist_ff;
   logic [uer_pkg::TMO_CFG_W-1:0] timeout_ff;

   // measurement state
   uer_pkg::phase_type phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] rise_ff, rise_in;
   logic [TIME_WIDTH-1:0] echo_ff, echo_in;
   logic [uer_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [uer_pkg::CNT_W-1:0] starts_ff, starts_in;
   logic [uer_pkg::CNT_W-1:0] rises_ff, rises_in;
   logic [uer_pkg::CNT_W-1:0] falls_ff, falls_in;
   logic [uer_pkg::CNT_W-1:0] timeouts_ff, timeouts_in;
   logic fire;

   // middle stage
   logic s1_vld_ff;
   uer_pkg::phase_type s1_phase_ff;
   logic [TIME_WIDTH-1:0] s1_echo_ff;
   logic s1_fire_ff;
   logic [uer_pkg::CNT_W-1:0] s1_starts_ff, s1_rises_ff, s1_falls_ff, s1_timeouts_ff;

   // output stage
   logic rsp_vld_ff;
   uer_pkg::rsp_word_type rsp_ff, rsp_in;

   logic advance;
   logic req_fire;
   logic busy;
   logic [TIME_WIDTH-1:0] cap_t;
   logic [uer_pkg::ELAPSED_W-1:0] elapsed_inc;
   logic [uer_pkg::MIN_BND_W-1:0] min_bound;
   logic [uer_pkg::MAX_BND_W-1:0] max_bound;
   logic [31:0] echo32;
   logic in_bounds;
   logic dist_ok;
   logic [uer_pkg::PROD_W-1:0] prod;

   assign advance = !rsp_vld_ff || rsp_ready;
   assign req_ready = !s1_vld_ff || advance;
   assign req_fire = req_valid && req_ready;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data = rsp_ff;

   assign busy = (phase_ff == uer_pkg::PH_WAIT_RISE) || (phase_ff == uer_pkg::PH_WAIT_FALL);
   assign cap_t = req_data.capture_time[TIME_WIDTH-1:0];
   assign elapsed_inc = (elapsed_ff < uer_pkg::ELAPSED_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;

   // next state
   always_comb begin
      phase_in = phase_ff;
      unique case (req_data.func)
         uer_pkg::FN_START: begin
            if (!busy) phase_in = uer_pkg::PH_WAIT_RISE;
         end
         uer_pkg::FN_EDGE: begin
            if (phase_ff == uer_pkg::PH_WAIT_RISE) phase_in = uer_pkg::PH_WAIT_FALL;
            else if (phase_ff == uer_pkg::PH_WAIT_FALL) phase_in = uer_pkg::PH_DONE;
         end
         uer_pkg::FN_TICK: begin
            if (busy && (elapsed_inc > uer_pkg::ELAPSED_W'(timeout_ff))) begin
               phase_in = uer_pkg::PH_TIMEOUT;
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   // datapath
   always_comb begin
      rise_in = rise_ff;
      echo_in = echo_ff;
      elapsed_in = elapsed_ff;
      starts_in = starts_ff;
      rises_in = rises_ff;
      falls_in = falls_ff;
      timeouts_in = timeouts_ff;
      fire = 1'b0;
      unique case (req_data.func)
         uer_pkg::FN_START: begin
            if (!busy) begin
               rise_in = '0;
               echo_in = '0;
               elapsed_in = '0;
               starts_in = starts_ff + 1'b1;
               fire = 1'b1;
            end
         end
         uer_pkg::FN_EDGE: begin
            if (phase_ff == uer_pkg::PH_WAIT_RISE) begin
               rise_in = cap_t;
               rises_in = rises_ff + 1'b1;
            end else if (phase_ff == uer_pkg::PH_WAIT_FALL) begin
               echo_in = cap_t - rise_ff;
               falls_in = falls_ff + 1'b1;
            end
         end
         uer_pkg::FN_TICK: begin
            if (busy) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc > uer_pkg::ELAPSED_W'(timeout_ff)) begin
                  echo_in = '0;
                  timeouts_in = timeouts_ff + 1'b1;
               end
            end
         end
         default: fire = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= uer_pkg::MIN_DISTANCE_RST;
         timeout_ff <= uer_pkg::TIMEOUT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            uer_pkg::CSR_MIN_DISTANCE: min_dist_ff <= csr_wdata[uer_pkg::MIN_CFG_W-1:0];
            uer_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata[uer_pkg::TMO_CFG_W-1:0];
            default: timeout_ff <= timeout_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uer_pkg::PH_IDLE;
         rise_ff <= '0;
         echo_ff <= '0;
         elapsed_ff <= '0;
         starts_ff <= '0;
         rises_ff <= '0;
         falls_ff <= '0;
         timeouts_ff <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         rise_ff <= rise_in;
         echo_ff <= echo_in;
         elapsed_ff <= elapsed_in;
         starts_ff <= starts_in;
         rises_ff <= rises_in;
         falls_ff <= falls_in;
         timeouts_ff <= timeouts_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_phase_ff <= phase_in;
         s1_echo_ff <= echo_in;
         s1_fire_ff <= fire;
         s1_starts_ff <= starts_in;
         s1_rises_ff <= rises_in;
         s1_falls_ff <= falls_in;
         s1_timeouts_ff <= timeouts_in;
      end
   end

   // bounds and divide by 58
   assign min_bound = uer_pkg::MIN_BND_W'(min_dist_ff) * uer_pkg::US_PER_CM;
   assign max_bound = uer_pkg::MAX_BND_W'(timeout_ff) * uer_pkg::US_PER_MS;
   assign echo32 = 32'(s1_echo_ff);
   assign in_bounds = (echo32 >= 32'(min_bound)) && (echo32 <= 32'(max_bound));
   assign dist_ok = (s1_phase_ff == uer_pkg::PH_DONE) && in_bounds;
   assign prod = uer_pkg::PROD_W'(echo32[uer_pkg::DIV_IN_W-1:0])
      * uer_pkg::PROD_W'(uer_pkg::RECIP_58);

   always_comb begin
      rsp_in.phase = s1_phase_ff;
      rsp_in.echo_width_us = echo32;
      rsp_in.range_cm = dist_ok
         ? uer_pkg::DIST_W'(prod[uer_pkg::PROD_W-1:uer_pkg::RECIP_SHIFT]) : '0;
      rsp_in.distance_valid = dist_ok;
      rsp_in.trigger_fire = s1_fire_ff;
      rsp_in.starts_seen = s1_starts_ff;
      rsp_in.rises_seen = s1_rises_ff;
      rsp_in.falls_seen = s1_falls_ff;
      rsp_in.timeouts_seen = s1_timeouts_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   a_valid_means_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.distance_valid |-> rsp_data.phase == uer_pkg::PH_DONE)
      else $error("distance_valid outside done");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.distance_valid |-> rsp_data.range_cm == '0)
      else $error("distance nonzero while invalid");

   a_fire_arms: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && s1_fire_ff |-> s1_phase_ff == uer_pkg::PH_WAIT_RISE)
      else $error("trigger without arming");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !advance |=> s1_vld_ff && $stable(s1_echo_ff))
      else $error("middle stage lost under stall");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_vld_ff && phase_ff == uer_pkg::PH_IDLE)
      else $error("reset did not clear pipeline");

endmodule

`default_nettype wire
